// ===== hw/rtl/rgbhsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL package
// Shared widths, fixed-point constants, transfer types and the restoring
// division step used by the RGB to HSL pixel pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

    localparam int FRACTION_BITS = 4;
    localparam int SCALE         = 1 << FRACTION_BITS;

    localparam int CH_W    = 8;
    localparam int CH_MAX  = 255;
    localparam int SUM_W   = CH_W + 1;
    localparam int XH_W    = CH_W + 3;

    localparam int HUE_W   = 13;
    localparam int SAT_W   = 11;
    localparam int LIGHT_W = 11;

    localparam int PCT_FULL   = 100 * SCALE;
    localparam int HUE_SECTOR = 60 * SCALE;
    localparam int HUE_FULL   = 360 * SCALE;

    // Every dividend is below 2^QUO_W times its divisor, so the upper
    // dividend bits always start as a remainder smaller than the divisor.
    localparam int QUO_W      = $clog2(HUE_FULL);
    localparam int NUM_W      = QUO_W + CH_W;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;

    // Lightness divides by twice the channel maximum through a rounded-up
    // reciprocal; the shift keeps the error below one unit of the result.
    localparam int          LIGHT_DEN    = 2 * CH_MAX;
    localparam int          LIGHT_SHIFT  = 25 + FRACTION_BITS;
    localparam int          LIGHT_PROD_W = LIGHT_SHIFT + LIGHT_W;
    localparam logic [63:0] LIGHT_RECIP  =
        ((64'd1 << LIGHT_SHIFT) + 64'(LIGHT_DEN - 1)) / 64'(LIGHT_DEN);
    localparam logic [63:0] LIGHT_FACTOR = LIGHT_RECIP * 64'(PCT_FULL);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel_in;

    typedef struct packed {
        logic [HUE_W-1:0]   hue_deg;
        logic [SAT_W-1:0]   saturation_pct;
        logic [LIGHT_W-1:0] lightness_pct;
    } t_pixel_out;

    typedef struct packed {
        logic [NUM_W-1:0]   hue_num;
        logic [CH_W-1:0]    hue_dvs;
        logic [NUM_W-1:0]   sat_num;
        logic [CH_W-1:0]    sat_dvs;
        logic [LIGHT_W-1:0] light;
    } t_work;

    typedef struct packed {
        logic [CH_W-1:0]  rem;
        logic [QUO_W-1:0] rest;
    } t_div_lane;

    // One restoring step: the next dividend bit enters the remainder and
    // the quotient bit fills the vacated position at the bottom.
    function automatic t_div_lane div_step(t_div_lane cur, logic [CH_W-1:0] dvs);
        logic [CH_W:0] trial;
        logic [CH_W:0] diff;
        t_div_lane     nxt;
        trial = {cur.rem, cur.rest[QUO_W-1]};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs}) begin
            nxt.rem  = diff[CH_W-1:0];
            nxt.rest = {cur.rest[QUO_W-2:0], 1'b1};
        end else begin
            nxt.rem  = trial[CH_W-1:0];
            nxt.rest = {cur.rest[QUO_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// ===== hw/rtl/rgbhsl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL front end
// Three pipeline stages: input capture, channel extremes and differences,
// then dividends, divisors and lightness for the division pipeline.
// ----------------------------------------------------------------------------
module rgbhsl_front
    import rgbhsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_pixel_in i_pixel,
    output logic      o_valid,
    input  logic      i_stall,
    output t_work     o_work
);

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } t_max_sel;

    logic      r_v1;
    t_pixel_in r_pix;

    logic                   r_v2;
    logic [CH_W-1:0]        r_d;
    logic [SUM_W-1:0]       r_sum;
    t_max_sel               r_sel;
    logic signed [CH_W:0]   r_diff;

    logic  r_v3;
    t_work r_work;

    logic st1;
    logic st2;
    logic st3;

    logic [CH_W-1:0]      mx;
    logic [CH_W-1:0]      mn;
    logic [CH_W-1:0]      lo_rg;
    logic [CH_W-1:0]      n_d;
    logic [SUM_W-1:0]     n_sum;
    t_max_sel             n_sel;
    logic signed [CH_W:0] n_diff;

    logic [XH_W-1:0]         xh;
    logic [XH_W-1:0]         d_x;
    logic [SUM_W-1:0]        den_full;
    logic [LIGHT_PROD_W-1:0] light_prod;
    logic                    grey;
    t_work                   n_work;

    assign st3     = r_v3 && i_stall;
    assign st2     = r_v2 && st3;
    assign st1     = r_v1 && st2;
    assign o_stall = st1;
    assign o_valid = r_v3;
    assign o_work  = r_work;

    always_comb begin
        if (r_pix.red >= r_pix.green && r_pix.red >= r_pix.blue) begin
            n_sel  = SEL_RED;
            mx     = r_pix.red;
            n_diff = $signed({1'b0, r_pix.green}) - $signed({1'b0, r_pix.blue});
        end else if (r_pix.green >= r_pix.blue) begin
            n_sel  = SEL_GREEN;
            mx     = r_pix.green;
            n_diff = $signed({1'b0, r_pix.blue}) - $signed({1'b0, r_pix.red});
        end else begin
            n_sel  = SEL_BLUE;
            mx     = r_pix.blue;
            n_diff = $signed({1'b0, r_pix.red}) - $signed({1'b0, r_pix.green});
        end
        lo_rg = (r_pix.red < r_pix.green) ? r_pix.red : r_pix.green;
        mn    = (r_pix.blue < lo_rg) ? r_pix.blue : lo_rg;
        n_d   = mx - mn;
        n_sum = SUM_W'(mx) + SUM_W'(mn);
    end

    always_comb begin
        d_x = XH_W'(r_d);
        case (r_sel)
            SEL_RED: begin
                if (r_diff[CH_W]) begin
                    xh = XH_W'(r_diff) + (d_x << 2) + (d_x << 1);
                end else begin
                    xh = XH_W'(r_diff);
                end
            end
            SEL_GREEN: xh = (d_x << 1) + XH_W'(r_diff);
            SEL_BLUE:  xh = (d_x << 2) + XH_W'(r_diff);
            default:   xh = '0;
        endcase

        den_full = (r_sum < SUM_W'(CH_MAX)) ? r_sum : SUM_W'(LIGHT_DEN) - r_sum;
        grey     = (r_d == '0);

        light_prod = LIGHT_PROD_W'(r_sum) * LIGHT_PROD_W'(LIGHT_FACTOR);

        n_work.hue_num = grey ? '0 : NUM_W'(xh) * NUM_W'(HUE_SECTOR);
        n_work.hue_dvs = grey ? CH_W'(1) : r_d;
        n_work.sat_num = grey ? '0 : NUM_W'(r_d) * NUM_W'(PCT_FULL);
        n_work.sat_dvs = grey ? CH_W'(1) : den_full[CH_W-1:0];
        n_work.light   = light_prod[LIGHT_SHIFT +: LIGHT_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!st1) begin
                r_v1 <= i_valid;
            end
            if (!st2) begin
                r_v2 <= r_v1;
            end
            if (!st3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!st1) begin
            r_pix <= i_pixel;
        end
        if (!st2) begin
            r_d    <= n_d;
            r_sum  <= n_sum;
            r_sel  <= n_sel;
            r_diff <= n_diff;
        end
        if (!st3) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== hw/rtl/rgbhsl_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL division pipeline
// Hue and saturation quotients by restoring division, two quotient bits per
// stage and one in the last, with lightness and valid bits carried alongside.
// ----------------------------------------------------------------------------
module rgbhsl_div
    import rgbhsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_work      i_work,
    output logic       o_valid,
    input  logic       i_stall,
    output t_pixel_out o_result
);

    logic [DIV_STAGES-1:0] r_v;
    t_div_lane             r_hue     [DIV_STAGES];
    t_div_lane             r_sat     [DIV_STAGES];
    logic [CH_W-1:0]       r_hue_dvs [DIV_STAGES];
    logic [CH_W-1:0]       r_sat_dvs [DIV_STAGES];
    logic [LIGHT_W-1:0]    r_light   [DIV_STAGES];

    logic [DIV_STAGES-1:0] stall;
    logic [DIV_STAGES-1:0] src_v;
    t_div_lane             src_hue     [DIV_STAGES];
    t_div_lane             src_sat     [DIV_STAGES];
    logic [CH_W-1:0]       src_hue_dvs [DIV_STAGES];
    logic [CH_W-1:0]       src_sat_dvs [DIV_STAGES];
    logic [LIGHT_W-1:0]    src_light   [DIV_STAGES];
    t_div_lane             n_hue       [DIV_STAGES];
    t_div_lane             n_sat       [DIV_STAGES];

    always_comb begin
        stall[DIV_STAGES-1] = r_v[DIV_STAGES-1] && i_stall;
        for (int s = DIV_STAGES - 2; s >= 0; s--) begin
            stall[s] = r_v[s] && stall[s+1];
        end
    end

    assign o_stall = stall[0];
    assign o_valid = r_v[DIV_STAGES-1];

    always_comb begin
        src_v[0]            = i_valid;
        src_hue[0].rem      = i_work.hue_num[NUM_W-1 -: CH_W];
        src_hue[0].rest     = i_work.hue_num[QUO_W-1:0];
        src_sat[0].rem      = i_work.sat_num[NUM_W-1 -: CH_W];
        src_sat[0].rest     = i_work.sat_num[QUO_W-1:0];
        src_hue_dvs[0]      = i_work.hue_dvs;
        src_sat_dvs[0]      = i_work.sat_dvs;
        src_light[0]        = i_work.light;
        for (int s = 1; s < DIV_STAGES; s++) begin
            src_v[s]       = r_v[s-1];
            src_hue[s]     = r_hue[s-1];
            src_sat[s]     = r_sat[s-1];
            src_hue_dvs[s] = r_hue_dvs[s-1];
            src_sat_dvs[s] = r_sat_dvs[s-1];
            src_light[s]   = r_light[s-1];
        end
    end

    always_comb begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            n_hue[s] = src_hue[s];
            n_sat[s] = src_sat[s];
            for (int j = 0; j < DIV_STEP; j++) begin
                if (s * DIV_STEP + j < QUO_W) begin
                    n_hue[s] = div_step(n_hue[s], src_hue_dvs[s]);
                    n_sat[s] = div_step(n_sat[s], src_sat_dvs[s]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                if (!stall[s]) begin
                    r_v[s] <= src_v[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (!stall[s]) begin
                r_hue[s]     <= n_hue[s];
                r_sat[s]     <= n_sat[s];
                r_hue_dvs[s] <= src_hue_dvs[s];
                r_sat_dvs[s] <= src_sat_dvs[s];
                r_light[s]   <= src_light[s];
            end
        end
    end

    assign o_result.hue_deg        = HUE_W'(r_hue[DIV_STAGES-1].rest);
    assign o_result.saturation_pct = SAT_W'(r_sat[DIV_STAGES-1].rest);
    assign o_result.lightness_pct  = r_light[DIV_STAGES-1];

endmodule

// ===== hw/rtl/rgb_to_hsl_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL pixel converter
// Converts one 8-bit RGB pixel per clock, when not stalled, into hue,
// saturation and lightness in fixed point with four fraction bits, truncated.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one pixel per transfer on i_pixel, qualified by
// i_valid and held back by o_stall. The output channel carries one result
// per pixel on o_pixel, qualified by o_valid and held back by i_stall.
// A pixel's result passes through the front end, the division pipeline and
// the output register before it is offered on o_pixel. A new pixel may be
// transferred on every cycle in which o_stall is low, so throughput is one
// pixel per clock without stalls; the hue and saturation quotients come
// from a seven-stage division pipeline resolving up to two bits per stage.
// Synchronous reset empties every stage; results start again with the
// first pixel transferred after reset.
// When the receiver stalls, the held result stays on o_pixel and earlier
// stages keep filling empty slots; o_stall rises only once every stage
// holding a pixel is blocked, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel
    import rgbhsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_pixel_in  i_pixel,
    output logic       o_valid,
    input  logic       i_stall,
    output t_pixel_out o_pixel
);

    logic       front_valid;
    logic       front_stall;
    t_work      front_work;
    logic       div_valid;
    t_pixel_out div_result;
    logic       out_stall;

    logic       r_out_v;
    t_pixel_out r_out;

    rgbhsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .o_valid (front_valid),
        .i_stall (front_stall),
        .o_work  (front_work)
    );

    rgbhsl_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (front_valid),
        .o_stall  (front_stall),
        .i_work   (front_work),
        .o_valid  (div_valid),
        .i_stall  (out_stall),
        .o_result (div_result)
    );

    assign out_stall = r_out_v && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (!out_stall) begin
            r_out_v <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_stall) begin
            r_out <= div_result;
        end
    end

    assign o_valid = r_out_v;
    assign o_pixel = r_out;

`ifndef SYNTHESIS
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel.hue_deg < HUE_W'(HUE_FULL)) &&
                    (o_pixel.saturation_pct <= SAT_W'(PCT_FULL)) &&
                    (o_pixel.lightness_pct <= LIGHT_W'(PCT_FULL)))
        else $error("result field out of range");

    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel.saturation_pct == '0) |-> (o_pixel.hue_deg == '0))
        else $error("grey pixel with non-zero hue");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result offered straight after reset");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL pixel converter testbench
// Drives pixels through the valid/stall input channel and checks every
// result against a predictor of the conversion. The predictor works in
// exact integer arithmetic with truncating division. Directed corner cases
// come first. Random pixels follow, with random idling on both sides, a
// stretch of back-to-back streaming, and a long receiver hold-off that
// fills the pipeline until the input stalls.
// ----------------------------------------------------------------------------
module testbench;
    import rgbhsl_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 400000;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_pixel_in  i_pixel = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_pixel_out o_pixel;

    t_pixel_out expected_hsl[$];

    bit sender_idle_on   = 1'b0;
    bit receiver_idle_on = 1'b0;
    int hold_requests    = 0;
    int holds_served     = 0;
    int hold_left        = 0;
    int stall_left       = 0;
    int cycle_count      = 0;
    int error_count      = 0;
    int pixels_sent      = 0;
    int results_checked  = 0;
    int input_stall_cycles = 0;

    rgb_to_hsl_pixel dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic t_pixel_out hsl_of_pixel(t_pixel_in px);
        int r, g, b, mx, mn, d, sum, den, num;
        t_pixel_out res;
        r   = px.red;
        g   = px.green;
        b   = px.blue;
        mx  = r;
        mn  = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d   = mx - mn;
        sum = mx + mn;
        res = '0;
        res.lightness_pct = LIGHT_W'((PCT_FULL * sum) / (2 * CH_MAX));
        if (d != 0) begin
            den = (sum < CH_MAX) ? sum : (2 * CH_MAX - sum);
            res.saturation_pct = SAT_W'((PCT_FULL * d) / den);
            if (r == mx) begin
                num = g - b;
            end else if (g == mx) begin
                num = 2 * d + (b - r);
            end else begin
                num = 4 * d + (r - g);
            end
            num = num * HUE_SECTOR;
            if (num < 0) num = num + HUE_FULL * d;
            res.hue_deg = HUE_W'(num / d);
        end
        return res;
    endfunction

    function automatic t_pixel_in make_pixel(int r, int g, int b);
        t_pixel_in px;
        px.red   = CH_W'(r);
        px.green = CH_W'(g);
        px.blue  = CH_W'(b);
        return px;
    endfunction

    // Mostly uniform pixels, with a share of greys, pairs of equal channels,
    // pixels near the lightness boundary and saturated channels.
    function automatic t_pixel_in random_pixel();
        int ch[3];
        int mx, mn, tmp, i, j;
        case ($urandom_range(0, 9))
            0: begin
                ch[0] = $urandom_range(0, CH_MAX);
                ch[1] = ch[0];
                ch[2] = ch[0];
            end
            1: begin
                ch[0] = $urandom_range(0, CH_MAX);
                ch[1] = ch[0];
                ch[2] = $urandom_range(0, CH_MAX);
            end
            2: begin
                mx    = $urandom_range(128, CH_MAX);
                mn    = CH_MAX - mx + $urandom_range(0, 2) - 1;
                if (mn < 0) mn = 0;
                if (mn > mx) mn = mx;
                ch[0] = mx;
                ch[1] = mn;
                ch[2] = $urandom_range(mn, mx);
            end
            3: begin
                ch[0] = $urandom_range(0, 1) * CH_MAX;
                ch[1] = $urandom_range(0, 1) * CH_MAX;
                ch[2] = $urandom_range(0, CH_MAX);
            end
            default: begin
                ch[0] = $urandom_range(0, CH_MAX);
                ch[1] = $urandom_range(0, CH_MAX);
                ch[2] = $urandom_range(0, CH_MAX);
            end
        endcase
        i     = $urandom_range(0, 2);
        j     = $urandom_range(0, 2);
        tmp   = ch[i];
        ch[i] = ch[j];
        ch[j] = tmp;
        return make_pixel(ch[0], ch[1], ch[2]);
    endfunction

    function automatic int pause_length();
        int k;
        k = $urandom_range(0, 19);
        if (k < 10) return 0;
        if (k < 17) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Valid stays high between back-to-back pixels; within a stream it is only
    // lowered when a pause is taken before the next one.
    task automatic send_pixel(t_pixel_in px);
        int gap;
        gap = sender_idle_on ? pause_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic end_stream();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_hsl.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_pixels();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        send_pixel(make_pixel(0, 0, 0));
        send_pixel(make_pixel(255, 255, 255));
        send_pixel(make_pixel(128, 128, 128));
        send_pixel(make_pixel(255, 0, 0));
        send_pixel(make_pixel(0, 255, 0));
        send_pixel(make_pixel(0, 0, 255));
        send_pixel(make_pixel(255, 0, 10));
        send_pixel(make_pixel(255, 255, 0));
        send_pixel(make_pixel(0, 255, 255));
        send_pixel(make_pixel(255, 0, 255));
        send_pixel(make_pixel(200, 55, 100));
        send_pixel(make_pixel(200, 54, 100));
        send_pixel(make_pixel(1, 0, 0));
        send_pixel(make_pixel(255, 254, 254));
        send_pixel(make_pixel(170, 85, 15));
        send_pixel(make_pixel(85, 170, 240));
        send_pixel(make_pixel(254, 1, 127));
        send_pixel(make_pixel(127, 128, 0));
        send_pixel(make_pixel(0, 127, 128));
        send_pixel(make_pixel(10, 20, 255));
        send_pixel(make_pixel(0, 1, 1));
        end_stream();
    endtask

    task automatic test_random_pixels(int count);
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        repeat (count) send_pixel(random_pixel());
        end_stream();
    endtask

    task automatic test_streaming(int count);
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        repeat (count) send_pixel(random_pixel());
        end_stream();
    endtask

    task automatic test_backpressure(int count);
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        hold_requests    = hold_requests + 1;
        repeat (count) send_pixel(random_pixel());
        end_stream();
    endtask

    // Receiver: a requested hold-off takes priority over random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left = hold_left - 1;
        end else if (holds_served < hold_requests) begin
            i_stall      <= 1'b1;
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES - 1;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left = stall_left - 1;
        end else if (receiver_idle_on && $urandom_range(0, 3) == 0) begin
            i_stall    <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Each accepted pixel queues its expected result; each result transfer
    // is compared with the oldest one.
    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && i_valid && o_stall) input_stall_cycles++;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_hsl.push_back(hsl_of_pixel(i_pixel));
            pixels_sent++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_hsl.size() == 0) begin
                $display("%0t: result with no pixel outstanding: hue %0d sat %0d light %0d",
                         $time, o_pixel.hue_deg, o_pixel.saturation_pct,
                         o_pixel.lightness_pct);
                error_count++;
            end else begin
                want = expected_hsl.pop_front();
                results_checked++;
                if (o_pixel.hue_deg !== want.hue_deg) begin
                    $display("%0t: hue_deg expected %0d actual %0d",
                             $time, want.hue_deg, o_pixel.hue_deg);
                    error_count++;
                end
                if (o_pixel.saturation_pct !== want.saturation_pct) begin
                    $display("%0t: saturation_pct expected %0d actual %0d",
                             $time, want.saturation_pct, o_pixel.saturation_pct);
                    error_count++;
                end
                if (o_pixel.lightness_pct !== want.lightness_pct) begin
                    $display("%0t: lightness_pct expected %0d actual %0d",
                             $time, want.lightness_pct, o_pixel.lightness_pct);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, expected_hsl.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_pixels();
        test_random_pixels(500);
        test_streaming(150);
        test_backpressure(80);
        test_random_pixels(220);
        if (expected_hsl.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_hsl.size());
            error_count++;
        end
        $display("Converted %0d pixels and checked %0d results, covering greys, tied maxima,",
                 pixels_sent, results_checked);
        $display("the lightness boundary and random idling; input stalled for %0d cycles.",
                 input_stall_cycles);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
